>>> src/svm_pkg.sv
// Package for the supply voltage monitor: widths, reset values, codes and shared types.
// Holds the restoring divider step and the grading function used by the back end.
// Depends on nothing; every other file imports it.
package svm_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 18;
    localparam int COUNT_W     = 7;
    localparam int VOLT_W      = 24;
    localparam int THRESH_W    = 16;
    localparam int GRADE_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(64);
    localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(1);
    localparam logic [VOLT_W-1:0]  VOLTAGE_MAX = '1;

    // Two quotient bits per cycle over the full dividend width.
    localparam int DIV_CYCLES = VOLT_W / 2;
    localparam int STEP_W     = $clog2(DIV_CYCLES);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_CYCLES - 1);

    localparam logic [COUNT_W-1:0]  RESET_AVERAGE_COUNT = COUNT_W'(20);
    localparam logic [VOLT_W-1:0]   RESET_SCALE         = VOLT_W'(5013504);
    localparam logic [THRESH_W-1:0] RESET_NORMAL_THRESH = THRESH_W'(2400);
    localparam logic [THRESH_W-1:0] RESET_LOW_THRESH    = THRESH_W'(2200);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AVERAGE_COUNT    = 2'd0,
        CFG_SCALE_NUMERATOR  = 2'd1,
        CFG_NORMAL_THRESHOLD = 2'd2,
        CFG_LOW_THRESHOLD    = 2'd3
    } cfg_index_t;

    typedef enum logic [GRADE_W-1:0] {
        GRADE_NORMAL  = 2'd0,
        GRADE_LOW     = 2'd1,
        GRADE_TOO_LOW = 2'd2
    } grade_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_AVG,
        BK_VOLT,
        BK_DONE
    } back_state_t;

    // One classified item passed from front to back.
    typedef struct packed {
        logic               complete;
        logic               classify;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [VOLT_W-1:0] quo;
    } div_state_t;

    // One restoring step: shift the next dividend bit into the remainder,
    // subtract where it fits and shift the quotient bit in at the bottom.
    function automatic div_state_t div_step(div_state_t s, logic [SUM_W-1:0] divisor);
        logic [SUM_W:0] shifted;
        logic [SUM_W:0] trial;
        div_state_t     r;
        shifted = {s.rem, s.quo[VOLT_W-1]};
        trial   = shifted - {1'b0, divisor};
        if (!trial[SUM_W])
        begin
            r.rem = trial[SUM_W-1:0];
            r.quo = {s.quo[VOLT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = shifted[SUM_W-1:0];
            r.quo = {s.quo[VOLT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic grade_t grade_of(logic [VOLT_W-1:0] v,
                                        logic [THRESH_W-1:0] normal_thresh,
                                        logic [THRESH_W-1:0] low_thresh);
        grade_t g;
        if (v > VOLT_W'(normal_thresh))
            g = GRADE_NORMAL;
        else if (v > VOLT_W'(low_thresh))
            g = GRADE_LOW;
        else
            g = GRADE_TOO_LOW;
        return g;
    endfunction

endpackage

>>> src/svm_front.sv
// Front end of the supply voltage monitor: accepts samples and accumulates them.
// Emits one command per item, marking those that complete an average. Uses svm_pkg.
module svm_front
    import svm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                classify_enable,
    input  logic [COUNT_W-1:0]  average_count,
    output cmd_t                cmd,
    output logic                cmd_push
);

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] counter_reg;
    logic [COUNT_W-1:0] counter_next;
    logic [COUNT_W-1:0] count_eff;
    logic [SUM_W-1:0]   sum_inc;
    logic [COUNT_W-1:0] counter_inc;
    logic               complete;

    // Clamp the count into the supported range.
    always_comb
    begin
        if (average_count == '0)
            count_eff = MIN_COUNT;
        else if (average_count > MAX_COUNT)
            count_eff = MAX_COUNT;
        else
            count_eff = average_count;
    end

    assign sum_inc     = sum_reg + SUM_W'(sample);
    assign counter_inc = counter_reg + COUNT_W'(1);
    assign complete    = (counter_inc >= count_eff);

    always_comb
    begin
        sum_next     = sum_reg;
        counter_next = counter_reg;
        if (accept)
        begin
            if (complete)
            begin
                sum_next     = '0;
                counter_next = '0;
            end
            else
            begin
                sum_next     = sum_inc;
                counter_next = counter_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            counter_reg <= '0;
        end
        else
        begin
            sum_reg     <= sum_next;
            counter_reg <= counter_next;
        end
    end

    assign cmd_push     = accept;
    assign cmd.complete = complete;
    assign cmd.classify = classify_enable;
    assign cmd.sum      = sum_inc;
    assign cmd.count    = count_eff;

endmodule

>>> src/svm_queue.sv
// Two-entry command queue between front and back of the supply voltage monitor.
// Uses cmd_t from svm_pkg.
module svm_queue
    import svm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t wr_cmd,
    input  logic wr_en,
    output logic full,
    output cmd_t rd_cmd,
    output logic rd_valid,
    input  logic rd_en
);

    cmd_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_wr;
    logic       do_rd;

    assign full     = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = entries_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_wr && !do_rd)
            fill_next = fill_reg + 2'd1;
        else if (do_rd && !do_wr)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

endmodule

>>> src/svm_back.sv
// Back end of the supply voltage monitor: two divisions on one shared iterative
// divider, grading and the result register. Uses svm_pkg.
module svm_back
    import svm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    input  logic [VOLT_W-1:0]   scale_numerator,
    input  logic [THRESH_W-1:0] normal_threshold,
    input  logic [THRESH_W-1:0] low_threshold,
    output logic [VOLT_W-1:0]   voltage_mv,
    output logic [GRADE_W-1:0]  grade,
    output logic                voltage_updated,
    output logic                empty,
    input  logic                pop
);

    back_state_t        state_reg;
    back_state_t        state_next;
    div_state_t         div_reg;
    div_state_t         div_next;
    div_state_t         div_one;
    div_state_t         div_two;
    logic [SUM_W-1:0]   divisor_reg;
    logic [SUM_W-1:0]   divisor_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               classify_reg;
    logic               classify_next;
    logic               updated_reg;
    logic               updated_next;
    logic [VOLT_W-1:0]  voltage_reg;
    logic [VOLT_W-1:0]  voltage_next;
    grade_t             grade_reg;
    grade_t             grade_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VOLT_W-1:0]  out_voltage_reg;
    logic [VOLT_W-1:0]  out_voltage_next;
    grade_t             out_grade_reg;
    grade_t             out_grade_next;
    logic               out_updated_reg;
    logic               out_updated_next;
    logic               last_step;
    logic               out_free;
    logic [SUM_W-1:0]   avg;

    assign div_one   = div_step(div_reg, divisor_reg);
    assign div_two   = div_step(div_one, divisor_reg);
    assign last_step = (step_reg == LAST_STEP);
    assign out_free  = !out_valid_reg || pop;
    assign avg       = div_two.quo[SUM_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                    state_next = cmd.complete ? BK_AVG : BK_DONE;
            end
            BK_AVG:
            begin
                if (last_step)
                    state_next = (avg == '0) ? BK_DONE : BK_VOLT;
            end
            BK_VOLT:
            begin
                if (last_step)
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop          = 1'b0;
        div_next         = div_reg;
        divisor_next     = divisor_reg;
        step_next        = step_reg;
        classify_next    = classify_reg;
        updated_next     = updated_reg;
        voltage_next     = voltage_reg;
        grade_next       = grade_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_voltage_next = out_voltage_reg;
        out_grade_next   = out_grade_reg;
        out_updated_next = out_updated_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop       = 1'b1;
                    classify_next = cmd.classify;
                    updated_next  = cmd.complete;
                    div_next.rem  = '0;
                    div_next.quo  = VOLT_W'(cmd.sum);
                    divisor_next  = SUM_W'(cmd.count);
                    step_next     = '0;
                end
            end
            BK_AVG:
            begin
                div_next  = div_two;
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    if (avg == '0)
                        voltage_next = VOLTAGE_MAX;
                    div_next.rem = '0;
                    div_next.quo = scale_numerator;
                    divisor_next = avg;
                    step_next    = '0;
                end
            end
            BK_VOLT:
            begin
                div_next  = div_two;
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                    voltage_next = div_two.quo;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    if (classify_reg)
                        grade_next = grade_of(voltage_reg, normal_threshold, low_threshold);
                    out_valid_next   = 1'b1;
                    out_voltage_next = voltage_reg;
                    out_grade_next   = classify_reg
                        ? grade_of(voltage_reg, normal_threshold, low_threshold)
                        : grade_reg;
                    out_updated_next = updated_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            voltage_reg   <= '0;
            grade_reg     <= GRADE_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            voltage_reg   <= voltage_next;
            grade_reg     <= grade_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg         <= div_next;
        divisor_reg     <= divisor_next;
        step_reg        <= step_next;
        classify_reg    <= classify_next;
        updated_reg     <= updated_next;
        out_voltage_reg <= out_voltage_next;
        out_grade_reg   <= out_grade_next;
        out_updated_reg <= out_updated_next;
    end

    assign empty           = !out_valid_reg;
    assign voltage_mv      = out_voltage_reg;
    assign grade           = out_grade_reg;
    assign voltage_updated = out_updated_reg;

endmodule

>>> src/supply_voltage_monitor_top.sv
// Top level of the supply voltage monitor: configuration registers, front end,
// command queue and back end. Uses svm_pkg, svm_front, svm_queue and svm_back.
//
// Usage:
//   Input channel: present sample and classify_enable with push; an item is
//   taken at a clock edge with push high and full low. Result channel: while
//   empty is low the oldest result sits on voltage_mv, grade and
//   voltage_updated; pop high at a clock edge takes it. Every item gives
//   exactly one result, in order.
//   Configuration: cfg_write high at a clock edge writes cfg_data into the
//   register chosen by cfg_index (average count, scale numerator, normal and
//   low thresholds). Write only while the block holds no items.
//   Back end: an item that does not complete an average passes from idle
//   straight to the result step; one that completes it goes through the
//   shared divider, which retires two quotient bits a cycle over 24-bit
//   dividends for two divisions in turn, the second skipped when the
//   average is zero. The front end keeps accumulating into a two-entry
//   queue while the back end divides, so full only rises once that fills.
//   Reset clears sums, counters, the held voltage and grade, the queue and
//   the result register, and reloads the configuration defaults.
//   When the receiver stalls, the result register holds its item and the
//   back end waits; the queue then fills and full stalls the sender.
module supply_voltage_monitor_top
    import svm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic                   classify_enable,
    input  logic                   push,
    output logic                   full,
    output logic [VOLT_W-1:0]      voltage_mv,
    output logic [GRADE_W-1:0]     grade,
    output logic                   voltage_updated,
    output logic                   empty,
    input  logic                   pop,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [COUNT_W-1:0]  average_count_reg;
    logic [VOLT_W-1:0]   scale_reg;
    logic [THRESH_W-1:0] normal_thresh_reg;
    logic [THRESH_W-1:0] low_thresh_reg;

    cmd_t front_cmd;
    logic front_push;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_pop;
    logic accept;

    // Take an item whenever the queue has room.
    assign accept = push && !full;

    // Configuration registers; writes land directly, no handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_count_reg <= RESET_AVERAGE_COUNT;
            scale_reg         <= RESET_SCALE;
            normal_thresh_reg <= RESET_NORMAL_THRESH;
            low_thresh_reg    <= RESET_LOW_THRESH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_AVERAGE_COUNT:    average_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_SCALE_NUMERATOR:  scale_reg         <= cfg_data[VOLT_W-1:0];
                CFG_NORMAL_THRESHOLD: normal_thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_LOW_THRESHOLD:    low_thresh_reg    <= cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Accumulate samples and mark the ones that close an average.
    svm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .sample          (sample),
        .classify_enable (classify_enable),
        .average_count   (average_count_reg),
        .cmd             (front_cmd),
        .cmd_push        (front_push)
    );

    // Decouple accumulation from the slow divider.
    svm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .wr_en    (front_push),
        .full     (full),
        .rd_cmd   (queue_cmd),
        .rd_valid (queue_valid),
        .rd_en    (queue_pop)
    );

    // Divide, grade and hold the result for the receiver.
    svm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (queue_cmd),
        .cmd_valid        (queue_valid),
        .cmd_pop          (queue_pop),
        .scale_numerator  (scale_reg),
        .normal_threshold (normal_thresh_reg),
        .low_threshold    (low_thresh_reg),
        .voltage_mv       (voltage_mv),
        .grade            (grade),
        .voltage_updated  (voltage_updated),
        .empty            (empty),
        .pop              (pop)
    );

endmodule
